### src/rims_pkg.sv
// rims_pkg: shared types and constants for the run insertion merge sorter
// record layout, key select codes, controller command and status structs
// used by rims_ctrl, rims_dp and run_insertion_merge_sorter
`timescale 1ns / 1ps

package rims_pkg;

  localparam int DEF_MAX_RECORDS = 64;
  localparam int DEF_RUN_LENGTH  = 32;

  localparam int KEY_W  = 20;
  localparam int TAG_W  = 16;
  localparam int REC_W  = TAG_W + KEY_W;
  localparam int SEL_W  = 3;
  localparam int IN_W   = 4 * KEY_W + TAG_W;
  localparam int OUT_W  = ((REC_W + 7) / 8) * 8;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-1:0] ADDR_KEY_SELECT = 3'd0;
  localparam logic [SEL_W-1:0]  KEY_SELECT_RESET = 3'd1;

  localparam logic [SEL_W-1:0] SEL_COST       = 3'd1;
  localparam logic [SEL_W-1:0] SEL_RATING     = 3'd2;
  localparam logic [SEL_W-1:0] SEL_TIMELINESS = 3'd3;
  localparam logic [SEL_W-1:0] SEL_SAFETY     = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS_RUN,
    ST_INS_CHK,
    ST_INS_RD,
    ST_INS_CAP,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_MRG_PASS,
    ST_MRG_PAIR,
    ST_CPY,
    ST_CPY_END,
    ST_MRG_INIT,
    ST_MRG_LA,
    ST_MRG_RA,
    ST_MRG_STEP,
    ST_MRG_FL,
    ST_MRG_FR,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic load_en;
    logic start_init;
    logic run_setup;
    logic run_next;
    logic ins_rd_i;
    logic ins_cap;
    logic ins_shift;
    logic ins_put;
    logic w_init;
    logic w_double;
    logic left_init;
    logic left_next;
    logic pair_setup;
    logic cpy_rd;
    logic mrg_rd_l;
    logic mrg_rd_r;
    logic cap_l;
    logic cap_r;
    logic mrg_take;
    logic emit_init;
    logic emit_rd;
    logic emit_ld;
  } cmd_t;

  typedef struct packed {
    logic accept_last;
    logic sel_ok;
    logic start_ge_n;
    logic i_ge_end;
    logic shift;
    logic j_more;
    logic w_ge_n;
    logic pair_skip;
    logic k_last_cpy;
    logic o_done;
    logic take_left;
    logic l_more;
    logic r_more;
    logic out_free;
    logic k_last_emit;
  } status_t;

endpackage

### src/run_insertion_merge_sorter.sv
// run_insertion_merge_sorter: top level with apb key select register,
// controller and datapath; depends on rims_pkg, rims_ctrl, rims_dp
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+-------------------------
//  s        | s_tvalid s_tready s_tdata s_tlast         | records in, tlast ends set
//  m        | m_tvalid m_tready m_tdata m_tlast         | sorted items out
//  apb      | psel penable pwrite paddr pwdata prdata   | key_select at address 0
//
// loading takes one item per cycle while s_tready is high; the last item starts the sort,
// or emission unsorted if key_select is invalid; insertion: each record is read, captured,
// compared and put, larger records shift up (store port); merge pass: each pair is copied
// to scratch and merged back; emission: per result, a registered store read then the output load
// s_tready is low from the last item until the final result enters the output
// register; reset clears control state only, the stores need no clearing pass
`timescale 1ns / 1ps

module run_insertion_merge_sorter import rims_pkg::*; #(
  parameter int MAX_RECORDS = DEF_MAX_RECORDS,
  parameter int RUN_LENGTH  = DEF_RUN_LENGTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // cost_key, rating_key, timeliness_key, safety_key, record_tag
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  // sorted_tag, sorted_key, zero padding
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [SEL_W-1:0] key_select;
  logic             addr_hit;
  cmd_t             cmd;
  status_t          status;

  assign pready   = 1'b1;
  assign addr_hit = paddr[APB_AW-1] == ADDR_KEY_SELECT[APB_AW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_select <= KEY_SELECT_RESET;
    end else if (psel && penable && pwrite && pready && addr_hit) begin
      key_select <= pwdata[SEL_W-1:0];
    end
  end

  assign prdata = addr_hit ? {{(APB_DW-SEL_W){1'b0}}, key_select} : '0;

  rims_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rims_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .RUN_LENGTH  (RUN_LENGTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .key_select (key_select),
    .cmd        (cmd),
    .status     (status),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

### src/rims_ram.sv
// rims_ram: generic single write port, single read port ram
// read data registered; no dependencies
`timescale 1ns / 1ps

module rims_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/rims_ctrl.sv
// rims_ctrl: sequencer for load, run insertion sort, bottom-up merge and emission
// depends on rims_pkg for state, command and status types
`timescale 1ns / 1ps

module rims_ctrl import rims_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.accept_last) begin
          state_next = status.sel_ok ? ST_INS_RUN : ST_EMIT_RD;
        end
      end
      ST_INS_RUN:  state_next = status.start_ge_n ? ST_MRG_PASS : ST_INS_CHK;
      ST_INS_CHK:  state_next = status.i_ge_end ? ST_INS_RUN : ST_INS_RD;
      ST_INS_RD:   state_next = ST_INS_CAP;
      ST_INS_CAP:  state_next = ST_INS_CMP;
      ST_INS_CMP: begin
        if (!(status.shift && status.j_more)) begin
          state_next = ST_INS_PUT;
        end
      end
      ST_INS_PUT:  state_next = ST_INS_CHK;
      ST_MRG_PASS: state_next = status.w_ge_n ? ST_EMIT_RD : ST_MRG_PAIR;
      ST_MRG_PAIR: state_next = status.pair_skip ? ST_MRG_PASS : ST_CPY;
      ST_CPY: begin
        if (status.k_last_cpy) begin
          state_next = ST_CPY_END;
        end
      end
      ST_CPY_END:  state_next = ST_MRG_INIT;
      ST_MRG_INIT: state_next = ST_MRG_LA;
      ST_MRG_LA:   state_next = ST_MRG_RA;
      ST_MRG_RA:   state_next = ST_MRG_STEP;
      ST_MRG_STEP: begin
        if (status.o_done) begin
          state_next = ST_MRG_PAIR;
        end else if (status.take_left) begin
          state_next = status.l_more ? ST_MRG_FL : ST_MRG_STEP;
        end else begin
          state_next = status.r_more ? ST_MRG_FR : ST_MRG_STEP;
        end
      end
      ST_MRG_FL:   state_next = ST_MRG_STEP;
      ST_MRG_FR:   state_next = ST_MRG_STEP;
      ST_EMIT_RD: begin
        if (status.out_free) begin
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD:  state_next = status.k_last_emit ? ST_IDLE : ST_EMIT_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load_en = 1'b1;
        if (status.accept_last) begin
          cmd.start_init = status.sel_ok;
          cmd.emit_init  = !status.sel_ok;
        end
      end
      ST_INS_RUN: begin
        cmd.run_setup = !status.start_ge_n;
        cmd.w_init    = status.start_ge_n;
      end
      ST_INS_CHK:  cmd.run_next = status.i_ge_end;
      ST_INS_RD:   cmd.ins_rd_i = 1'b1;
      ST_INS_CAP:  cmd.ins_cap = 1'b1;
      ST_INS_CMP:  cmd.ins_shift = status.shift;
      ST_INS_PUT:  cmd.ins_put = 1'b1;
      ST_MRG_PASS: begin
        cmd.emit_init = status.w_ge_n;
        cmd.left_init = !status.w_ge_n;
      end
      ST_MRG_PAIR: begin
        cmd.w_double   = status.pair_skip;
        cmd.pair_setup = !status.pair_skip;
      end
      ST_CPY:      cmd.cpy_rd = 1'b1;
      ST_CPY_END:  cmd = '0;
      ST_MRG_INIT: cmd.mrg_rd_l = 1'b1;
      ST_MRG_LA: begin
        cmd.cap_l    = 1'b1;
        cmd.mrg_rd_r = 1'b1;
      end
      ST_MRG_RA:   cmd.cap_r = 1'b1;
      ST_MRG_STEP: begin
        cmd.left_next = status.o_done;
        cmd.mrg_take  = !status.o_done;
      end
      ST_MRG_FL:   cmd.cap_l = 1'b1;
      ST_MRG_FR:   cmd.cap_r = 1'b1;
      ST_EMIT_RD:  cmd.emit_rd = status.out_free;
      ST_EMIT_LD:  cmd.emit_ld = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

### src/rims_dp.sv
// rims_dp: datapath with record store, merge scratch, index registers and output register
// depends on rims_pkg and rims_ram; driven by rims_ctrl commands
`timescale 1ns / 1ps

module rims_dp import rims_pkg::*; #(
  parameter int MAX_RECORDS = DEF_MAX_RECORDS,
  parameter int RUN_LENGTH  = DEF_RUN_LENGTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [SEL_W-1:0] key_select,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int PW = $clog2(3 * MAX_RECORDS + RUN_LENGTH + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RECORDS);
  localparam logic [PW-1:0] RUN_P   = PW'(RUN_LENGTH);
  localparam logic [PW-1:0] ONE_P   = PW'(1);
  localparam logic [PW-1:0] TWO_P   = PW'(2);

  logic [CW-1:0]    count, n;
  logic [PW-1:0]    start, run_end, i, j, w, left, mid, right, k, l, r, o;
  logic [REC_W-1:0] rec, lrec, rrec, out_rec;
  logic             cpy_pend, out_valid, out_last;
  logic [AW-1:0]    cpy_addr;

  logic [KEY_W-1:0] in_key;
  logic [TAG_W-1:0] in_tag;
  logic             sel_ok, accept, has_room;
  logic [CW-1:0]    count_inc;
  logic [PW-1:0]    n_p, start_run, left_w, left_2w, k_inc;

  logic             st_we;
  logic [AW-1:0]    st_waddr, st_raddr, sc_raddr;
  logic [REC_W-1:0] st_wdata, st_rdata, sc_rdata;

  always_comb begin
    in_key = '0;
    sel_ok = 1'b1;
    case (key_select)
      SEL_COST:       in_key = s_tdata[KEY_W-1:0];
      SEL_RATING:     in_key = s_tdata[2*KEY_W-1:KEY_W];
      SEL_TIMELINESS: in_key = s_tdata[3*KEY_W-1:2*KEY_W];
      SEL_SAFETY:     in_key = s_tdata[4*KEY_W-1:3*KEY_W];
      default:        sel_ok = 1'b0;
    endcase
  end

  assign in_tag    = s_tdata[IN_W-1:4*KEY_W];
  assign s_tready  = cmd.load_en;
  assign accept    = cmd.load_en && s_tvalid;
  assign has_room  = count < CNT_MAX;
  assign count_inc = has_room ? count + CW'(1) : count;

  assign n_p       = PW'(n);
  assign start_run = start + RUN_P;
  assign left_w    = left + w;
  assign left_2w   = left + (w << 1);
  assign k_inc     = k + ONE_P;

  assign status.accept_last = accept && s_tlast;
  assign status.sel_ok      = sel_ok;
  assign status.start_ge_n  = start >= n_p;
  assign status.i_ge_end    = i >= run_end;
  assign status.shift       = st_rdata[KEY_W-1:0] > rec[KEY_W-1:0];
  assign status.j_more      = j > start + ONE_P;
  assign status.w_ge_n      = w >= n_p;
  assign status.pair_skip   = (left >= n_p) || (left_w >= n_p);
  assign status.k_last_cpy  = k_inc == right;
  assign status.o_done      = o == right;
  assign status.take_left   = (l < mid) &&
                              ((r >= right) || (lrec[KEY_W-1:0] < rrec[KEY_W-1:0]));
  assign status.l_more      = l + ONE_P < mid;
  assign status.r_more      = r + ONE_P < right;
  assign status.out_free    = !out_valid || m_tready;
  assign status.k_last_emit = k_inc == n_p;

  // load counter and set size
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= s_tlast ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      n <= count_inc;
    end
  end

  // insertion sort indices
  always_ff @(posedge clk) begin
    if (cmd.start_init) begin
      start <= '0;
    end else if (cmd.run_next) begin
      start <= start_run;
    end
    if (cmd.run_setup) begin
      run_end <= (start_run > n_p) ? n_p : start_run;
    end
    if (cmd.run_setup) begin
      i <= start + ONE_P;
    end else if (cmd.ins_put) begin
      i <= i + ONE_P;
    end
    if (cmd.ins_cap) begin
      j   <= i;
      rec <= st_rdata;
    end else if (cmd.ins_shift) begin
      j <= j - ONE_P;
    end
  end

  // merge indices and heads
  always_ff @(posedge clk) begin
    if (cmd.w_init) begin
      w <= RUN_P;
    end else if (cmd.w_double) begin
      w <= w << 1;
    end
    if (cmd.left_init) begin
      left <= '0;
    end else if (cmd.left_next) begin
      left <= left_2w;
    end
    if (cmd.pair_setup) begin
      mid   <= left_w;
      right <= (left_2w > n_p) ? n_p : left_2w;
      l     <= left;
      r     <= left_w;
      o     <= left;
    end else if (cmd.mrg_take) begin
      o <= o + ONE_P;
      if (status.take_left) begin
        l <= l + ONE_P;
      end else begin
        r <= r + ONE_P;
      end
    end
    if (cmd.cap_l) begin
      lrec <= sc_rdata;
    end
    if (cmd.cap_r) begin
      rrec <= sc_rdata;
    end
  end

  // copy and emission pointer
  always_ff @(posedge clk) begin
    if (cmd.pair_setup) begin
      k <= left;
    end else if (cmd.emit_init) begin
      k <= '0;
    end else if (cmd.cpy_rd || cmd.emit_ld) begin
      k <= k_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpy_pend <= 1'b0;
    end else begin
      cpy_pend <= cmd.cpy_rd;
    end
  end

  always_ff @(posedge clk) begin
    cpy_addr <= k[AW-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_rec  <= st_rdata;
      out_last <= status.k_last_emit;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_W-REC_W){1'b0}}, out_rec[KEY_W-1:0],
                     out_rec[REC_W-1:KEY_W]};

  // store ports
  always_comb begin
    st_we    = 1'b0;
    st_waddr = count[AW-1:0];
    st_wdata = {in_tag, in_key};
    if (accept && has_room) begin
      st_we = 1'b1;
    end else if (cmd.ins_shift) begin
      st_we    = 1'b1;
      st_waddr = j[AW-1:0];
      st_wdata = st_rdata;
    end else if (cmd.ins_put) begin
      st_we    = 1'b1;
      st_waddr = j[AW-1:0];
      st_wdata = rec;
    end else if (cmd.mrg_take) begin
      st_we    = 1'b1;
      st_waddr = o[AW-1:0];
      st_wdata = status.take_left ? lrec : rrec;
    end
  end

  always_comb begin
    st_raddr = k[AW-1:0];
    if (cmd.ins_rd_i) begin
      st_raddr = i[AW-1:0];
    end else if (cmd.ins_cap) begin
      st_raddr = AW'(i - ONE_P);
    end else if (cmd.ins_shift) begin
      st_raddr = AW'(j - TWO_P);
    end else if (cmd.emit_rd || cmd.cpy_rd) begin
      st_raddr = k[AW-1:0];
    end
  end

  always_comb begin
    sc_raddr = l[AW-1:0];
    if (cmd.mrg_rd_r) begin
      sc_raddr = r[AW-1:0];
    end else if (cmd.mrg_rd_l) begin
      sc_raddr = l[AW-1:0];
    end else if (cmd.mrg_take) begin
      sc_raddr = status.take_left ? AW'(l + ONE_P) : AW'(r + ONE_P);
    end
  end

  rims_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  rims_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_scratch (
    .clk   (clk),
    .we    (cpy_pend),
    .waddr (cpy_addr),
    .wdata (st_rdata),
    .raddr (sc_raddr),
    .rdata (sc_rdata)
  );

`ifndef SYNTHESIS
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    status.accept_last |=> count == '0)
    else $error("record count not cleared after last record");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ld |-> !out_valid)
    else $error("output register overwritten while holding an item");

  a_merge_src: assert property (@(posedge clk) disable iff (rst)
    cmd.mrg_take |-> (l < mid) || (r < right))
    else $error("merge step with both halves exhausted");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_shift |-> j > start)
    else $error("insertion shift below run start");
`endif

endmodule
